>>> hdl/gocp_pkg.sv
// Shared types and constants for the glyph outline to cubic path converter.
// Depends on nothing; imported by glyph_outline_to_cubic_path.
`default_nettype none

package gocp_pkg;

   // Coordinate widths: 18.6 input words and 1/384 pixel result words.
   localparam int IN_COORD_W  = 24;
   localparam int OUT_COORD_W = 28;

   // Point tag codes. Any tag with bit 0 set is an on-curve point.
   localparam logic [1:0] TAG_QUAD  = 2'd0;
   localparam logic [1:0] TAG_CUBIC = 2'd2;

   // Result queue depth and the derived pointer and count widths.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_MOVE  = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_CUBIC = 2'd2,
      KIND_CLOSE = 2'd3
   } elem_kind_type;

   typedef logic signed [OUT_COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   typedef struct packed {
      elem_kind_type kind;
      point_type     ctrl1;
      point_type     ctrl2;
      point_type     end_pt;
      logic          last;
   } elem_type;

endpackage

`default_nettype wire

>>> hdl/glyph_outline_to_cubic_path.sv
// Glyph outline to cubic path converter, top level.
// Depends on gocp_pkg for coordinate, point and path element types.
`default_nettype none

// The block takes one outline point per item on the req_ channel and returns
// path elements (move, line, cubic, close) on the rsp_ channel. Each point
// carries the glyph origin, its tag, contour start and end marks, and the
// contour's last point, which is used only when a contour starts off-curve.
//
// An accepted item is held in an input register. Once the queue has room,
// the conversion logic updates the held points and writes zero, one or two
// elements into a four-entry result queue, which rsp_ presents in order. One
// item is accepted per cycle while the queue holds at most two elements; a
// point that ends a contour usually yields two elements, so a run of those
// fills the queue and holds up acceptance while rsp_ drains it.
//
// Held coordinates are kept in thirds of the output unit: every control point
// is a multiple of six and every implied midpoint a multiple of three, so the
// quadratic raise (2*c1 + c0) / 3 becomes an add with no divider.
//
// Reset clears the held points to zero with one point held, empties the
// queue and drops any item in the input register. When the receiver stalls,
// the queue fills and req_tready falls once fewer than two entries are free.
module glyph_outline_to_cubic_path
   import gocp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata from bit 0 up: point_x, point_y, wrap_x, wrap_y,
   // origin_x, origin_y, 24 bits each.
   input  wire logic [143:0] req_tdata,
   // req_tuser from bit 0 up: point_tag (2), contour_first (1).
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tlast,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // rsp_tdata from bit 0 up: ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x,
   // end_y, 28 bits each.
   output logic [167:0]      rsp_tdata,
   // rsp_tuser: element_kind (2).
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);

   // ---------------------------------------------------------------------
   // Coordinate helpers.
   // ---------------------------------------------------------------------
   function automatic coord_type ext24(input logic [IN_COORD_W-1:0] v);
      ext24 = coord_type'($signed(v));
   endfunction

   // Midpoint of two held points; the sum is always even.
   function automatic point_type pmid(input point_type a, input point_type b);
      logic signed [OUT_COORD_W:0] sx;
      logic signed [OUT_COORD_W:0] sy;
      sx = {a.x[OUT_COORD_W-1], a.x} + {b.x[OUT_COORD_W-1], b.x};
      sy = {a.y[OUT_COORD_W-1], a.y} + {b.y[OUT_COORD_W-1], b.y};
      pmid.x = sx[OUT_COORD_W:1];
      pmid.y = sy[OUT_COORD_W:1];
   endfunction

   // Quadratic raise: (2*c1 + c0) / 3 of true values equals 2*c1 + c0 of thirds.
   function automatic point_type praise(input point_type c1, input point_type c0);
      praise.x = (c1.x <<< 1) + c0.x;
      praise.y = (c1.y <<< 1) + c0.y;
   endfunction

   // Held thirds back to output units.
   function automatic point_type ptri(input point_type u);
      ptri.x = (u.x <<< 1) + u.x;
      ptri.y = (u.y <<< 1) + u.y;
   endfunction

   function automatic elem_type mk(input elem_kind_type kind, input point_type a,
                                   input point_type b, input point_type e);
      mk.kind   = kind;
      mk.ctrl1  = a;
      mk.ctrl2  = b;
      mk.end_pt = e;
      mk.last   = 1'b0;
   endfunction

   localparam point_type ZERO_PT = '0;

   // ---------------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------------
   logic                  in_vld_ff, in_vld_in;
   logic [IN_COORD_W-1:0] in_px_ff, in_py_ff, in_wx_ff, in_wy_ff, in_ox_ff, in_oy_ff;
   logic [1:0]            in_tag_ff;
   logic                  in_first_ff, in_last_ff;

   // Held points in thirds of the output unit.
   point_type c0_ff, c1_ff, c2_ff, start_ff;
   point_type c0_in, c1_in, c2_in, start_in;
   logic [1:0] n_ff, n_in;

   // Result queue.
   elem_type            queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in, wr_b;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]          push_n;
   logic                pop, go, accept;

   logic      a_vld;
   elem_type  elem_a, elem_b;

   assign go         = in_vld_ff && (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_tready = !in_vld_ff || go;
   assign accept     = req_tvalid && req_tready;
   assign in_vld_in  = accept ? 1'b1 : (go ? 1'b0 : in_vld_ff);

   // ---------------------------------------------------------------------
   // Conversion logic.
   // ---------------------------------------------------------------------
   always_comb begin
      point_type s_pt;
      point_type w_pt;
      point_type pt;
      point_type mid_e;
      logic [1:0] n_cur;

      s_pt.x = ext24(in_ox_ff) + ext24(in_px_ff);
      s_pt.y = ext24(in_oy_ff) - ext24(in_py_ff);
      w_pt.x = ext24(in_ox_ff) + ext24(in_wx_ff);
      w_pt.y = ext24(in_oy_ff) - ext24(in_wy_ff);
      pt.x   = s_pt.x <<< 1;
      pt.y   = s_pt.y <<< 1;
      mid_e  = ZERO_PT;

      n_cur    = (n_ff == 2'd0) ? 2'd1 : n_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      start_in = start_ff;
      n_in     = n_cur;
      a_vld    = 1'b0;
      elem_a   = mk(KIND_CLOSE, ZERO_PT, ZERO_PT, ZERO_PT);

      if (in_first_ff) begin
         // An off-curve first point starts at its midpoint with the last point.
         if (in_tag_ff[0]) begin
            start_in = pt;
         end else begin
            start_in.x = s_pt.x + w_pt.x;
            start_in.y = s_pt.y + w_pt.y;
         end
         elem_a = mk(KIND_MOVE, ptri(start_in), ZERO_PT, ZERO_PT);
         a_vld  = 1'b1;
         c0_in  = start_in;
         n_in   = 2'd1;
      end else begin
         case (in_tag_ff)
            TAG_CUBIC: begin
               if (n_cur == 2'd3) begin
                  mid_e  = pmid(pt, c2_ff);
                  elem_a = mk(KIND_CUBIC, ptri(c1_ff), ptri(c2_ff), ptri(mid_e));
                  a_vld  = 1'b1;
                  c0_in  = mid_e;
                  c1_in  = pt;
                  n_in   = 2'd2;
               end else begin
                  if (n_cur == 2'd1) begin
                     c1_in = pt;
                  end else begin
                     c2_in = pt;
                  end
                  n_in = n_cur + 2'd1;
               end
            end
            TAG_QUAD: begin
               if (n_cur >= 2'd2) begin
                  mid_e  = (n_cur == 2'd2) ? pmid(c1_ff, pt) : pmid(c1_ff, c2_ff);
                  elem_a = mk(KIND_CUBIC, praise(c1_ff, c0_ff), praise(c1_ff, mid_e),
                              ptri(mid_e));
                  a_vld  = 1'b1;
                  c0_in  = mid_e;
               end
               c1_in = pt;
               n_in  = 2'd2;
            end
            default: begin
               // On-curve point closes whatever run is held.
               if (n_cur == 2'd1) begin
                  elem_a = mk(KIND_LINE, ptri(pt), ZERO_PT, ZERO_PT);
               end else if (n_cur == 2'd2) begin
                  elem_a = mk(KIND_CUBIC, praise(c1_ff, c0_ff), praise(c1_ff, pt),
                              ptri(pt));
               end else begin
                  elem_a = mk(KIND_CUBIC, ptri(c1_ff), ptri(c2_ff), ptri(pt));
               end
               a_vld = 1'b1;
               c0_in = pt;
               n_in  = 2'd1;
            end
         endcase
      end
      elem_a.last = !in_last_ff;

      // Contour end closes back to the start point using the updated state.
      if (n_in == 2'd2) begin
         elem_b = mk(KIND_CUBIC, praise(c1_in, c0_in), praise(c1_in, start_in),
                     ptri(start_in));
      end else if (n_in == 2'd3) begin
         elem_b = mk(KIND_CUBIC, ptri(c1_in), ptri(c2_in), ptri(start_in));
      end else begin
         elem_b = mk(KIND_CLOSE, ZERO_PT, ZERO_PT, ZERO_PT);
      end
      elem_b.last = 1'b1;
      if (in_last_ff) begin
         c0_in = start_in;
         n_in  = 2'd1;
      end
   end

   // ---------------------------------------------------------------------
   // Queue bookkeeping.
   // ---------------------------------------------------------------------
   assign pop    = rsp_tvalid && rsp_tready;
   assign push_n = go ? ({1'b0, a_vld} + {1'b0, in_last_ff}) : 2'd0;
   assign wr_b   = wr_ff + QPTR_W'(a_vld);
   assign wr_in  = wr_ff + QPTR_W'(push_n);
   assign rd_in  = rd_ff + QPTR_W'(pop);
   assign cnt_in = cnt_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         c0_ff     <= '0;
         c1_ff     <= '0;
         c2_ff     <= '0;
         start_ff  <= '0;
         n_ff      <= 2'd1;
         wr_ff     <= '0;
         rd_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (go) begin
            c0_ff    <= c0_in;
            c1_ff    <= c1_in;
            c2_ff    <= c2_in;
            start_ff <= start_in;
            n_ff     <= n_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers: input item and queue entries.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_px_ff    <= req_tdata[23:0];
         in_py_ff    <= req_tdata[47:24];
         in_wx_ff    <= req_tdata[71:48];
         in_wy_ff    <= req_tdata[95:72];
         in_ox_ff    <= req_tdata[119:96];
         in_oy_ff    <= req_tdata[143:120];
         in_tag_ff   <= req_tuser[1:0];
         in_first_ff <= req_tuser[2];
         in_last_ff  <= req_tlast;
      end
      if (go && a_vld) begin
         queue_mem[wr_ff] <= elem_a;
      end
      if (go && in_last_ff) begin
         queue_mem[wr_b] <= elem_b;
      end
   end

   // ---------------------------------------------------------------------
   // Result channel.
   // ---------------------------------------------------------------------
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {queue_mem[rd_ff].end_pt.y, queue_mem[rd_ff].end_pt.x,
                        queue_mem[rd_ff].ctrl2.y,  queue_mem[rd_ff].ctrl2.x,
                        queue_mem[rd_ff].ctrl1.y,  queue_mem[rd_ff].ctrl1.x};
   assign rsp_tuser  = queue_mem[rd_ff].kind;
   assign rsp_tlast  = queue_mem[rd_ff].last;

endmodule

`default_nettype wire

>>> dv/glyph_outline_to_cubic_path_tb.sv
// Self-checking testbench for glyph_outline_to_cubic_path: streams outline points and
// compares every path element against an in-bench conversion of the same points.
// Depends on gocp_pkg and the glyph_outline_to_cubic_path RTL.
module glyph_outline_to_cubic_path_tb;
   import gocp_pkg::*;

   localparam int COORD_MIN      = -8388608;
   localparam int COORD_MAX      = 8388607;
   localparam int WATCHDOG_LIMIT = 600;
   localparam int DRAIN_CYCLES   = 16;

   // On-curve tag codes; the package only names the two control tags.
   localparam logic [1:0] TAG_ON     = 2'd1;
   localparam logic [1:0] TAG_ON_ALT = 2'd3;

   typedef struct {
      logic signed [23:0] x, y, wrap_x, wrap_y, org_x, org_y;
      logic [1:0]         tag;
      logic               first, last;
   } outline_point_type;

   typedef struct {
      elem_kind_type kind;
      coord_type     c1x, c1y, c2x, c2y, ex, ey;
      logic          last;
   } path_elem_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic [143:0] req_tdata  = '0;
   logic [2:0]   req_tuser  = '0;
   logic         req_tlast  = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   // Converter state mirrored by the predictor.
   longint held_x [3] = '{0, 0, 0};
   longint held_y [3] = '{0, 0, 0};
   int     held_count = 1;
   longint contour_start_x = 0;
   longint contour_start_y = 0;

   path_elem_type step_elems [$];
   path_elem_type expected_elements [$];

   bit idling_on      = 1'b1;
   int error_count    = 0;
   int points_sent    = 0;
   int contours_sent  = 0;
   int elements_seen  = 0;
   int quiet_cycles   = 0;

   glyph_outline_to_cubic_path DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #1 clock = ~clock;

   function automatic void add_elem(elem_kind_type k, longint ax, longint ay, longint bx,
                                    longint by, longint ex, longint ey);
      path_elem_type e;
      e.kind = k;
      e.c1x  = coord_type'(ax);
      e.c1y  = coord_type'(ay);
      e.c2x  = coord_type'(bx);
      e.c2y  = coord_type'(by);
      e.ex   = coord_type'(ex);
      e.ey   = coord_type'(ey);
      e.last = 1'b0;
      step_elems.push_back(e);
   endfunction

   // Converts one accepted point into the path elements it causes and queues them.
   // Every division below is exact, since control points are multiples of six and every held point a multiple of three.
   function automatic void trace_outline_point(outline_point_type p);
      longint ox, oy, px, py, wx, wy, sxv, syv, ex, ey, ax, ay, bx, by;
      int     n;
      ox = p.org_x;
      oy = p.org_y;
      px = 6 * (ox + longint'(p.x));
      py = 6 * (oy - longint'(p.y));
      n  = (held_count == 0) ? 1 : held_count;
      step_elems.delete();

      if (p.first) begin
         sxv = px;
         syv = py;
         // An off-curve first point only sets up the midpoint with the last point.
         if (!p.tag[0]) begin
            wx  = 6 * (ox + longint'(p.wrap_x));
            wy  = 6 * (oy - longint'(p.wrap_y));
            sxv = (px + wx) / 2;
            syv = (py + wy) / 2;
         end
         contour_start_x = sxv;
         contour_start_y = syv;
         add_elem(KIND_MOVE, sxv, syv, 0, 0, 0, 0);
         held_x[0] = sxv;
         held_y[0] = syv;
         n = 1;
      end else if (p.tag == TAG_CUBIC) begin
         if (n == 3) begin
            // A third cubic control in a row: split at the midpoint of the last two.
            ex = (px + held_x[2]) / 2;
            ey = (py + held_y[2]) / 2;
            add_elem(KIND_CUBIC, held_x[1], held_y[1], held_x[2], held_y[2], ex, ey);
            held_x[0] = ex;
            held_y[0] = ey;
            held_x[1] = px;
            held_y[1] = py;
            n = 2;
         end else begin
            held_x[n] = px;
            held_y[n] = py;
            n++;
         end
      end else if (p.tag == TAG_QUAD) begin
         if (n >= 2) begin
            if (n == 2) begin
               ex = (held_x[1] + px) / 2;
               ey = (held_y[1] + py) / 2;
            end else begin
               ex = (held_x[1] + held_x[2]) / 2;
               ey = (held_y[1] + held_y[2]) / 2;
            end
            bx = (2 * held_x[1] + ex) / 3;
            by = (2 * held_y[1] + ey) / 3;
            ax = (2 * held_x[1] + held_x[0]) / 3;
            ay = (2 * held_y[1] + held_y[0]) / 3;
            add_elem(KIND_CUBIC, ax, ay, bx, by, ex, ey);
            held_x[0] = ex;
            held_y[0] = ey;
         end
         held_x[1] = px;
         held_y[1] = py;
         n = 2;
      end else begin
         if (n == 1) begin
            add_elem(KIND_LINE, px, py, 0, 0, 0, 0);
         end else if (n == 2) begin
            bx = (2 * held_x[1] + px) / 3;
            by = (2 * held_y[1] + py) / 3;
            ax = (2 * held_x[1] + held_x[0]) / 3;
            ay = (2 * held_y[1] + held_y[0]) / 3;
            add_elem(KIND_CUBIC, ax, ay, bx, by, px, py);
         end else begin
            add_elem(KIND_CUBIC, held_x[1], held_y[1], held_x[2], held_y[2], px, py);
         end
         held_x[0] = px;
         held_y[0] = py;
         n = 1;
      end

      // Closing a contour returns to its start through whatever is still held.
      if (p.last) begin
         if (n == 1) begin
            add_elem(KIND_CLOSE, 0, 0, 0, 0, 0, 0);
         end else if (n == 2) begin
            bx = (2 * held_x[1] + contour_start_x) / 3;
            by = (2 * held_y[1] + contour_start_y) / 3;
            ax = (2 * held_x[1] + held_x[0]) / 3;
            ay = (2 * held_y[1] + held_y[0]) / 3;
            add_elem(KIND_CUBIC, ax, ay, bx, by, contour_start_x, contour_start_y);
         end else begin
            add_elem(KIND_CUBIC, held_x[1], held_y[1], held_x[2], held_y[2],
                     contour_start_x, contour_start_y);
         end
         held_x[0] = contour_start_x;
         held_y[0] = contour_start_y;
         n = 1;
      end

      held_count = n;
      if (step_elems.size() > 0)
         step_elems[step_elems.size() - 1].last = 1'b1;
      foreach (step_elems[i])
         expected_elements.push_back(step_elems[i]);
   endfunction

   function automatic outline_point_type make_point(int x, int y, logic [1:0] tag,
                                                    bit first = 1'b0, bit last = 1'b0,
                                                    int wx = 0, int wy = 0,
                                                    int ox = 0, int oy = 0);
      outline_point_type p;
      p.x      = 24'(x);
      p.y      = 24'(y);
      p.tag    = tag;
      p.first  = first;
      p.last   = last;
      p.wrap_x = 24'(wx);
      p.wrap_y = 24'(wy);
      p.org_x  = 24'(ox);
      p.org_y  = 24'(oy);
      return p;
   endfunction

   function automatic logic signed [23:0] rand_coord();
      int v;
      v = int'($urandom_range(0, 4095)) - 2048;
      case ($urandom_range(0, 15))
         0:          return 24'(COORD_MIN);
         1:          return 24'(COORD_MAX);
         2, 3, 4, 5: return 24'(v);
         default:    return 24'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] rand_tag();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return TAG_QUAD;
         4, 5:       return TAG_CUBIC;
         6, 7, 8:    return TAG_ON;
         default:    return TAG_ON_ALT;
      endcase
   endfunction

   // Drives one point and returns at the edge that accepts it. Handshake state is
   // sampled at the falling edge, where nothing is changing.
   task automatic send_point(input outline_point_type p);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tdata  <= {p.org_y, p.org_x, p.wrap_y, p.wrap_x, p.y, p.x};
      req_tuser  <= {p.first, p.tag};
      req_tlast  <= p.last;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      trace_outline_point(p);
      points_sent++;
      if (p.first)
         contours_sent++;
      @(posedge clock);
   endtask

   // A well-formed contour: first and last marks in place and the first point's
   // wrap fields carrying the contour's final point.
   task automatic send_random_contour(input int max_len);
      outline_point_type pts [$];
      outline_point_type p;
      int                len;
      logic signed [23:0] ox, oy;
      len = $urandom_range(1, max_len);
      ox  = rand_coord();
      oy  = rand_coord();
      for (int i = 0; i < len; i++) begin
         p.x      = rand_coord();
         p.y      = rand_coord();
         p.tag    = rand_tag();
         p.first  = (i == 0);
         p.last   = (i == len - 1);
         p.org_x  = ox;
         p.org_y  = oy;
         p.wrap_x = rand_coord();
         p.wrap_y = rand_coord();
         pts.push_back(p);
      end
      pts[0].wrap_x = pts[len - 1].x;
      pts[0].wrap_y = pts[len - 1].y;
      foreach (pts[i])
         send_point(pts[i]);
   endtask

   // Points before any contour start continue from the reset state.
   task automatic test_headless_points();
      send_point(make_point(64, 64, TAG_ON));
      send_point(make_point(-128, 320, TAG_QUAD, 0, 0, 0, 0, 640, 640));
      send_point(make_point(192, -64, TAG_ON_ALT));
      send_point(make_point(500, 700, TAG_CUBIC));
   endtask

   task automatic test_directed_contours();
      // Single-point contour, which also discards the points held above.
      send_point(make_point(100, 200, TAG_ON, 1, 1, 50, -70, 1000, 2000));
      // Contour opening on a quadratic control: start at the midpoint with the wrap.
      send_point(make_point(0, 0, TAG_QUAD, 1, 0, 640, 0, 320, -320));
      send_point(make_point(640, 640, TAG_QUAD));
      send_point(make_point(0, 640, TAG_ON));
      send_point(make_point(640, 0, TAG_ON, 0, 1));
      // Contour opening on a cubic control, ending with two points held.
      send_point(make_point(10, 20, TAG_CUBIC, 1, 0, -30, 40, -5000, 7000));
      send_point(make_point(70, -90, TAG_CUBIC, 0, 0, 0, 0, -5000, 7000));
      send_point(make_point(130, 150, TAG_CUBIC, 0, 0, 0, 0, -5000, 7000));
      send_point(make_point(-30, 40, TAG_CUBIC, 0, 1, 0, 0, -5000, 7000));
      // Three cubic controls in a row, then an on-curve point at full range.
      send_point(make_point(COORD_MAX, COORD_MIN, TAG_ON, 1, 0, 0, 0, COORD_MAX, COORD_MIN));
      send_point(make_point(COORD_MIN, COORD_MAX, TAG_CUBIC, 0, 0, 0, 0, COORD_MAX, COORD_MIN));
      send_point(make_point(COORD_MAX, COORD_MAX, TAG_CUBIC, 0, 0, 0, 0, COORD_MAX, COORD_MIN));
      send_point(make_point(COORD_MIN, COORD_MIN, TAG_CUBIC, 0, 0, 0, 0, COORD_MAX, COORD_MIN));
      send_point(make_point(COORD_MAX, COORD_MIN, TAG_ON_ALT, 0, 1, 0, 0, COORD_MAX, COORD_MIN));
      // Closing with three points held.
      send_point(make_point(-64, -64, TAG_ON, 1, 0, 0, 0, 256, 256));
      send_point(make_point(64, -64, TAG_CUBIC, 0, 0, 0, 0, 256, 256));
      send_point(make_point(64, 64, TAG_CUBIC, 0, 1, 0, 0, 256, 256));
      // Quadratic run closing with two points held.
      send_point(make_point(0, 0, TAG_ON, 1, 0, 0, 0, -12, 34));
      send_point(make_point(300, 0, TAG_QUAD, 0, 0, 0, 0, -12, 34));
      send_point(make_point(300, 300, TAG_QUAD, 0, 1, 0, 0, -12, 34));
      // A contour start arriving mid-contour, with extreme origin and wrap.
      send_point(make_point(5, 5, TAG_ON, 1));
      send_point(make_point(9, 9, TAG_QUAD));
      send_point(make_point(COORD_MIN, COORD_MAX, TAG_QUAD, 1, 0, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MAX));
      send_point(make_point(COORD_MIN, COORD_MIN, TAG_ON_ALT, 0, 1, 0, 0,
                            COORD_MIN, COORD_MAX));
   endtask

   task automatic test_random_contours();
      int stop_at;
      stop_at = points_sent + 820;
      while (points_sent < stop_at)
         send_random_contour(10);
   endtask

   // Unstructured points: marks, tags and every field at random.
   task automatic test_noise_points();
      outline_point_type p;
      for (int i = 0; i < 100; i++) begin
         p.x      = rand_coord();
         p.y      = rand_coord();
         p.wrap_x = rand_coord();
         p.wrap_y = rand_coord();
         p.org_x  = rand_coord();
         p.org_y  = rand_coord();
         p.tag    = 2'($urandom);
         p.first  = ($urandom_range(0, 3) == 0);
         p.last   = ($urandom_range(0, 3) == 0);
         send_point(p);
      end
   endtask

   // Back-to-back traffic with the sender never idling and the receiver always ready.
   task automatic test_steady_stream();
      int stop_at;
      idling_on = 1'b0;
      stop_at = points_sent + 60;
      while (points_sent < stop_at)
         send_random_contour(6);
   endtask

   // Receiver back-pressure in random bursts while idling is enabled.
   always begin : rsp_stall_driver
      @(posedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clock);
   end

   function automatic void compare_field(string name, logic [27:0] want, logic [27:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         error_count++;
      end
   endfunction

   // Checks each element at the falling edge before the edge that accepts it,
   // and watches for a stall with no traffic on either side.
   always @(negedge clock) begin : rsp_monitor
      path_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         elements_seen++;
         if (expected_elements.size() == 0) begin
            $error("element of kind %0d arrived with none expected", rsp_tuser);
            error_count++;
         end else begin
            want = expected_elements.pop_front();
            compare_field("element_kind", want.kind, rsp_tuser);
            compare_field("ctrl1_x", want.c1x, rsp_tdata[27:0]);
            compare_field("ctrl1_y", want.c1y, rsp_tdata[55:28]);
            compare_field("ctrl2_x", want.c2x, rsp_tdata[83:56]);
            compare_field("ctrl2_y", want.c2y, rsp_tdata[111:84]);
            compare_field("end_x", want.ex, rsp_tdata[139:112]);
            compare_field("end_y", want.ey, rsp_tdata[167:140]);
            compare_field("last_of_run", want.last, rsp_tlast);
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d elements outstanding",
                  quiet_cycles, expected_elements.size());
         $display("glyph_outline_to_cubic_path test failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_headless_points();
      test_directed_contours();
      test_random_contours();
      test_noise_points();
      test_steady_stream();
      req_tvalid <= 1'b0;
      while (expected_elements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d outline points across %0d contours into %0d path elements.",
               points_sent, contours_sent, elements_seen);
      $display("Coverage: headless points, off-curve starts, control runs, noise, %0d errors.",
               error_count);
      if (error_count == 0)
         $display("glyph_outline_to_cubic_path test passed");
      else
         $display("glyph_outline_to_cubic_path test failed");
      $finish;
   end

endmodule
